@@ rtl/uvp_pkg.sv @@
package uvp_pkg;

  localparam int MAX_IMAGE_BYTES = 4096;
  localparam int HEADER_BYTES    = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOUT = 32'hFFFF_FFFF;

  localparam logic [7:0] STATE_DOWNLOADED = 8'h5A;
  localparam logic [7:0] STATE_APPLIED    = 8'hA5;
  localparam logic [7:0] ERASED_BYTE      = 8'hFF;

  localparam int MAGIC_LEN = 6;
  localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h4B, 8'h5A, 8'h4F, 8'h54, 8'h41, 8'h21};

  // header byte positions
  localparam logic [4:0] IDX_VERSION = 5'd6;
  localparam logic [4:0] IDX_CRC_LO  = 5'd7;
  localparam logic [4:0] IDX_CRC_HI  = 5'd10;
  localparam logic [4:0] IDX_LEN_LO  = 5'd11;
  localparam logic [4:0] IDX_LEN_HI  = 5'd12;
  localparam logic [4:0] IDX_STATE   = 5'd13;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_VALID     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_STATE = 3'd3;
  localparam logic [2:0] ST_CRC_BAD   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_IMAGE  = 2'd2,
    PH_DONE   = 2'd3
  } uvp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } uvp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pkg_version;
    logic        applied;
    logic [31:0] computed_crc;
  } uvp_out_t;

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/uvp_ingress.sv @@
module uvp_ingress import uvp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  uvp_in_t in_word,
  output logic    in_stall,
  input  logic    take,
  output logic    hold_valid,
  output uvp_in_t hold_word
);

  logic    valid_r, valid_nxt;
  uvp_in_t word_r;
  logic    load;

  // one-entry input register; refills in the cycle it drains
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
    end
  end

  assign hold_valid = valid_r;
  assign hold_word  = word_r;

endmodule

@@ rtl/uvp_core.sv @@
module uvp_core import uvp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  uvp_in_t  word,
  output logic     emit,
  output uvp_out_t result
);

  uvp_phase_t  phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        mg_r, mg_nxt;
  logic [1:0]  es_r, es_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sb_r, sb_nxt;
  logic [31:0] run_r, run_nxt;
  logic [15:0] left_r, left_nxt;

  // state as seen by this byte (a first byte restarts everything)
  uvp_phase_t  ph_b;
  logic [4:0]  idx_b;
  logic        mg_b;
  logic [1:0]  es_b;
  logic [7:0]  ver_b;
  logic [31:0] scrc_b;
  logic [15:0] len_b;
  logic [7:0]  sb_b;
  logic [31:0] run_b;
  logic [15:0] left_b;

  logic [7:0]  b;
  logic        hdr_end;
  logic        state_ok;
  logic        too_long;
  logic [31:0] crc_upd;
  logic [31:0] crc_fin;

  assign b = word.data_byte;

  // header capture and CRC datapath
  always_comb begin
    ph_b   = word.first ? PH_HEADER : phase_r;
    idx_b  = word.first ? 5'd0 : idx_r;
    mg_b   = word.first ? 1'b1 : mg_r;
    es_b   = word.first ? 2'b00 : es_r;
    ver_b  = word.first ? 8'd0 : ver_r;
    scrc_b = word.first ? 32'd0 : scrc_r;
    len_b  = word.first ? 16'd0 : len_r;
    sb_b   = word.first ? 8'd0 : sb_r;
    run_b  = word.first ? CRC_INIT : run_r;
    left_b = word.first ? 16'd0 : left_r;

    idx_nxt  = idx_b;
    mg_nxt   = mg_b;
    es_nxt   = es_b;
    ver_nxt  = ver_b;
    scrc_nxt = scrc_b;
    len_nxt  = len_b;
    sb_nxt   = sb_b;
    run_nxt  = run_b;
    left_nxt = left_b;

    crc_upd = crc_byte(run_b, b);
    crc_fin = crc_upd ^ CRC_XOUT;

    if (ph_b == PH_HEADER) begin
      idx_nxt = idx_b + 5'd1;
      if (idx_b < 5'(MAGIC_LEN) && b != MAGIC[idx_b[2:0]]) begin
        mg_nxt = 1'b0;
      end
      if (idx_b == 5'd0 && b == ERASED_BYTE) begin
        es_nxt[0] = 1'b1;
      end
      if (idx_b == 5'd1 && b == ERASED_BYTE) begin
        es_nxt[1] = 1'b1;
      end
      if (idx_b == IDX_VERSION) begin
        ver_nxt = b;
      end
      if (idx_b >= IDX_CRC_LO && idx_b <= IDX_CRC_HI) begin
        scrc_nxt = scrc_b | ({24'd0, b} << {idx_b[1:0] - 2'd3, 3'd0});
      end
      if (idx_b == IDX_LEN_LO) begin
        len_nxt[7:0] = b;
      end
      if (idx_b == IDX_LEN_HI) begin
        len_nxt[15:8] = b;
      end
      if (idx_b == IDX_STATE) begin
        sb_nxt = b;
      end
    end

    hdr_end  = (ph_b == PH_HEADER) && ({1'b0, idx_nxt} >= 6'(HEADER_BYTES));
    state_ok = (sb_nxt == STATE_DOWNLOADED) || (sb_nxt == STATE_APPLIED);
    too_long = {1'b0, len_nxt} > 17'(MAX_IMAGE_BYTES);

    if (hdr_end) begin
      run_nxt  = CRC_INIT;
      left_nxt = len_nxt;
    end else if (ph_b == PH_IMAGE) begin
      run_nxt  = crc_upd;
      left_nxt = left_b - 16'd1;
    end
  end

  // verdict
  always_comb begin
    emit   = 1'b0;
    result = '0;
    result.pkg_version = ver_nxt;
    result.applied     = (sb_nxt == STATE_APPLIED);
    if (hdr_end) begin
      emit = 1'b1;
      if (es_nxt == 2'b11) begin
        result.status = ST_NONE;
      end else if (!mg_nxt) begin
        result.status = ST_BAD_MAGIC;
      end else if (!state_ok) begin
        result.status = ST_BAD_STATE;
      end else if (too_long) begin
        result.status = ST_TOO_LONG;
      end else if (len_nxt == 16'd0) begin
        result.status = (scrc_nxt == 32'd0) ? ST_VALID : ST_CRC_BAD;
      end else begin
        emit = 1'b0;
      end
    end else if (ph_b == PH_IMAGE && left_nxt == 16'd0) begin
      emit = 1'b1;
      result.status       = (crc_fin == scrc_nxt) ? ST_VALID : ST_CRC_BAD;
      result.computed_crc = crc_fin;
    end
  end

  // phase
  always_comb begin
    phase_nxt = ph_b;
    case (ph_b)
      PH_HEADER: begin
        if (hdr_end) begin
          phase_nxt = emit ? PH_DONE : PH_IMAGE;
        end
      end
      PH_IMAGE: begin
        if (emit) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = ph_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= 5'd0;
      mg_r    <= 1'b1;
      es_r    <= 2'b00;
      ver_r   <= 8'd0;
      scrc_r  <= 32'd0;
      len_r   <= 16'd0;
      sb_r    <= 8'd0;
      run_r   <= CRC_INIT;
      left_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      mg_r    <= mg_nxt;
      es_r    <= es_nxt;
      ver_r   <= ver_nxt;
      scrc_r  <= scrc_nxt;
      len_r   <= len_nxt;
      sb_r    <= sb_nxt;
      run_r   <= run_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

@@ rtl/update_package_verifier_top.sv @@
// channel | direction | handshake           | word
// in      | input     | in_valid / in_stall   | uvp_in_t  {data_byte, first}
// out     | output    | out_valid / out_stall | uvp_out_t {status, pkg_version, applied,
//         |           |                       |            computed_crc}
//
// One byte per cycle sustained unless a stalled output word holds the flow. A byte is
// held in the input register, then header capture or the CRC byte update runs in one pass
// into the state registers, while a verdict is registered in the output register.
// Synchronous active-low reset clears phase, counters and the CRC to their idle values.
// A stalled output word holds; the input register keeps taking bytes while the
// output register is empty or being drained in the same cycle.
module update_package_verifier_top import uvp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  uvp_in_t  in_word,
  output logic     in_stall,
  output logic     out_valid,
  output uvp_out_t out_word,
  input  logic     out_stall
);

  logic     hold_valid;
  uvp_in_t  hold_word;
  logic     take;
  logic     emit;
  uvp_out_t result;

  logic     out_valid_r, out_valid_nxt;
  uvp_out_t out_word_r;

  // the held byte moves on whenever the output register has room this cycle
  assign take = hold_valid && (!out_valid_r || !out_stall);

  uvp_ingress u_ingress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_word  (hold_word)
  );

  uvp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (take),
    .word   (hold_word),
    .emit   (emit),
    .result (result)
  );

  // output register: load on a verdict, clear when drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  // input side only stalls with a byte held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_valid)
    else $error("in_stall without a held byte");

  // a verdict never lands while an undrained word would be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit) |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten");

  // status code within range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status <= ST_TOO_LONG))
    else $error("status out of range");

  // header verdicts carry no CRC
  a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_VALID && out_word.status != ST_CRC_BAD)
      |-> (out_word.computed_crc == 32'd0))
    else $error("nonzero CRC on header verdict");
`endif

endmodule
